// ===== hw/rtl/trle_pkg.sv =====
// Shared types and constants for the TGA run-length pixel decoder.
// No dependencies; used by every module in hw/rtl.
`timescale 1ns / 1ps
`default_nettype none

package trle_pkg;

    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PIXEL = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RLE_MODE        = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT    = 4'd3;

    localparam logic [2:0] BPP_RESET = 3'd4;
    localparam logic [2:0] BPP_RGB   = 3'd3;

    localparam logic [7:0] RUN_THRESHOLD = 8'd128;
    localparam logic [7:0] RUN_BIAS      = 8'd127;

    typedef struct packed {
        logic [2:0]  bytes_per_pixel;
        logic        rle_mode;
        logic [31:0] total_pixels;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  pixel_red;
        logic [7:0]  pixel_green;
        logic [7:0]  pixel_blue;
        logic [7:0]  pixel_alpha;
        logic [7:0]  repeat_count;
        logic [31:0] start_index;
        logic        image_done;
        logic        overrun;
    } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tga_rle_pixel_decoder_top.sv =====
// Top level of the TGA run-length pixel decoder.
// Depends on trle_pkg, trle_cfg_regs, trle_decode and trle_out_reg.
`timescale 1ns / 1ps
`default_nettype none

// Decodes a true-colour TGA pixel-data byte stream (raw or run-length packets)
// into RGB(A) pixels, each with its repeat count and start position. One byte
// is taken per cycle; a pixel appears on the m_ side in the cycle after its last
// byte and is held until taken. The rate is set by the result register: s_ready
// drops only while a result is held and m_ready is low, and in the cycle after
// each configuration write while the registered width * height product updates.
module tga_rle_pixel_decoder_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [trle_pkg::CFG_IDX_W-1:0]    cfg_wr_index,
    input  wire logic [trle_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [7:0]                        s_data_byte,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [7:0]                             m_pixel_red,
    output logic [7:0]                             m_pixel_green,
    output logic [7:0]                             m_pixel_blue,
    output logic [7:0]                             m_pixel_alpha,
    output logic [7:0]                             m_repeat_count,
    output logic [31:0]                            m_start_index,
    output logic                                   m_image_done,
    output logic                                   m_overrun
);

    trle_pkg::cfg_t    cfg;
    trle_pkg::result_t res;
    trle_pkg::result_t m_res;
    logic              cfg_settling;
    logic              can_load;
    logic              res_valid;
    logic              accept;

    trle_cfg_regs u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg),
        .cfg_settling (cfg_settling)
    );

    assign s_ready = can_load && !cfg_settling;
    assign accept  = s_valid && s_ready;

    trle_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .accept    (accept),
        .data_byte (s_data_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    trle_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept && res_valid),
        .res      (res),
        .m_ready  (m_ready),
        .m_valid  (m_valid),
        .m_res    (m_res),
        .can_load (can_load)
    );

    assign m_pixel_red    = m_res.pixel_red;
    assign m_pixel_green  = m_res.pixel_green;
    assign m_pixel_blue   = m_res.pixel_blue;
    assign m_pixel_alpha  = m_res.pixel_alpha;
    assign m_repeat_count = m_res.repeat_count;
    assign m_start_index  = m_res.start_index;
    assign m_image_done   = m_res.image_done;
    assign m_overrun      = m_res.overrun;

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("request taken while result register is stalled");

    a_cfg_settle: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> !s_ready)
        else $error("request taken before image size settled");

    a_overrun_ends_image: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_overrun |-> m_image_done)
        else $error("overrun without image end");

    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_repeat_count != 8'd0)
        else $error("pixel with zero repeat count");

    a_restart_at_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(m_valid && m_ready && m_image_done) && m_valid && !$stable(m_start_index)
        |-> m_start_index == 32'd0)
        else $error("image did not restart at position zero");

endmodule

`default_nettype wire

// ===== hw/rtl/trle_cfg_regs.sv =====
// Configuration registers and the registered image size (width * height).
// Depends on trle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module trle_cfg_regs (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [trle_pkg::CFG_IDX_W-1:0]    cfg_wr_index,
    input  wire logic [trle_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    output trle_pkg::cfg_t                         cfg,
    output logic                                   cfg_settling
);

    logic [2:0]  bpp_reg;
    logic        rle_reg;
    logic [15:0] width_reg;
    logic [15:0] height_reg;
    logic [31:0] total_reg;
    logic        settle_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpp_reg    <= trle_pkg::BPP_RESET;
            rle_reg    <= 1'b1;
            width_reg  <= 16'd1;
            height_reg <= 16'd1;
            total_reg  <= 32'd1;
            settle_reg <= 1'b0;
        end else begin
            settle_reg <= cfg_wr_en;
            total_reg  <= 32'(width_reg) * 32'(height_reg);
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    trle_pkg::CFG_BYTES_PER_PIXEL: bpp_reg    <= cfg_wr_data[2:0];
                    trle_pkg::CFG_RLE_MODE:        rle_reg    <= cfg_wr_data[0];
                    trle_pkg::CFG_IMAGE_WIDTH:     width_reg  <= cfg_wr_data;
                    trle_pkg::CFG_IMAGE_HEIGHT:    height_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
        end
    end

    // product is registered and lags a write; hold off requests meanwhile
    assign cfg.bytes_per_pixel = bpp_reg;
    assign cfg.rle_mode        = rle_reg;
    assign cfg.total_pixels    = total_reg;
    assign cfg_settling        = settle_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/trle_decode.sv =====
// Packet/pixel decode state and the single-pass next-result logic.
// Depends on trle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module trle_decode (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire trle_pkg::cfg_t    cfg,
    input  wire logic              accept,
    input  wire logic [7:0]        data_byte,
    output logic                   res_valid,
    output trle_pkg::result_t      res
);

    logic [31:0] pos_reg,     pos_next;
    logic        await_reg,   await_next;
    logic [1:0]  phase_reg,   phase_next;
    logic [7:0]  left_reg,    left_next;
    logic        run_reg,     run_next;
    logic [7:0]  len_reg,     len_next;
    logic [23:0] partial_reg, partial_next;

    logic [1:0]  last_phase;
    logic        in_image;
    logic [31:0] remaining;
    logic [7:0]  req;
    logic        req_over;
    logic [7:0]  count;
    logic        fills;
    logic        done;
    logic [7:0]  left_dec;

    always_comb begin
        last_phase = (cfg.bytes_per_pixel == trle_pkg::BPP_RGB) ? 2'd2 : 2'd3;
        in_image   = pos_reg < cfg.total_pixels;
        remaining  = in_image ? (cfg.total_pixels - pos_reg) : 32'd1;
        if (cfg.rle_mode && run_reg)
            req = (len_reg == 8'd0) ? 8'd1 : len_reg;
        else
            req = 8'd1;
        req_over = {24'd0, req} > remaining;
        count    = req_over ? remaining[7:0] : req;
        fills    = {24'd0, count} >= remaining;
        done     = !in_image || fills;
        left_dec = (left_reg > 8'd0) ? (left_reg - 8'd1) : 8'd0;
    end

    always_comb begin
        pos_next     = pos_reg;
        await_next   = await_reg;
        phase_next   = phase_reg;
        left_next    = left_reg;
        run_next     = run_reg;
        len_next     = len_reg;
        partial_next = partial_reg;
        res_valid    = 1'b0;

        res.pixel_blue   = partial_reg[7:0];
        res.pixel_green  = partial_reg[15:8];
        if (last_phase == 2'd2) begin
            res.pixel_red   = data_byte;
            res.pixel_alpha = 8'd0;
        end else begin
            res.pixel_red   = partial_reg[23:16];
            res.pixel_alpha = data_byte;
        end
        res.repeat_count = count;
        res.start_index  = pos_reg;
        res.image_done   = done;
        res.overrun      = req_over ||
                           (cfg.rle_mode && !run_reg && (left_reg > 8'd1) && fills);

        if (cfg.total_pixels != 32'd0) begin
            if (cfg.rle_mode && await_reg) begin
                if (data_byte < trle_pkg::RUN_THRESHOLD) begin
                    run_next  = 1'b0;
                    len_next  = 8'd0;
                    left_next = data_byte + 8'd1;
                end else begin
                    run_next  = 1'b1;
                    len_next  = data_byte - trle_pkg::RUN_BIAS;
                    left_next = 8'd0;
                end
                await_next = 1'b0;
                phase_next = 2'd0;
            end else if (phase_reg < last_phase) begin
                case (phase_reg)
                    2'd0:    partial_next[7:0]   = data_byte;
                    2'd1:    partial_next[15:8]  = data_byte;
                    default: partial_next[23:16] = data_byte;
                endcase
                phase_next = phase_reg + 2'd1;
            end else begin
                res_valid  = 1'b1;
                phase_next = 2'd0;
                if (cfg.rle_mode) begin
                    if (run_reg) begin
                        run_next   = 1'b0;
                        len_next   = 8'd0;
                        await_next = 1'b1;
                    end else begin
                        left_next = left_dec;
                        if (left_dec == 8'd0)
                            await_next = 1'b1;
                    end
                end
                if (done) begin
                    pos_next     = 32'd0;
                    await_next   = 1'b1;
                    left_next    = 8'd0;
                    run_next     = 1'b0;
                    len_next     = 8'd0;
                    partial_next = 24'd0;
                end else begin
                    pos_next = pos_reg + {24'd0, count};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= 32'd0;
            await_reg   <= 1'b1;
            phase_reg   <= 2'd0;
            left_reg    <= 8'd0;
            run_reg     <= 1'b0;
            len_reg     <= 8'd0;
            partial_reg <= 24'd0;
        end else if (accept) begin
            pos_reg     <= pos_next;
            await_reg   <= await_next;
            phase_reg   <= phase_next;
            left_reg    <= left_next;
            run_reg     <= run_next;
            len_reg     <= len_next;
            partial_reg <= partial_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/trle_out_reg.sv =====
// Result register on the m_ side: holds one decoded pixel until taken.
// Depends on trle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module trle_out_reg (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              load,
    input  wire trle_pkg::result_t res,
    input  wire logic              m_ready,
    output logic                   m_valid,
    output trle_pkg::result_t      m_res,
    output logic                   can_load
);

    logic              valid_reg;
    trle_pkg::result_t res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign can_load = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_res    = res_reg;

endmodule

`default_nettype wire
